FILE: sv/tbs_pkg.sv
// Shared types and constants for the token bucket shaper.
`default_nettype none

package tbs_pkg;

  localparam int TOKEN_SHIFT = 20;
  localparam int TOKEN_W     = 36;
  localparam int RATE_W      = 30;
  localparam int DEPTH_W     = 16;
  localparam int MINC_W      = 16;
  localparam int OVHD_W      = 8;
  localparam int LEN_W       = 16;
  localparam int TIME_W      = 32;
  localparam int CHARGE_W    = 17;
  localparam int REFILL_W    = TIME_W + RATE_W - TOKEN_SHIFT;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 30;

  localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(64000);
  localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(1500);
  localparam logic [MINC_W-1:0]  MINC_RST  = MINC_W'(256);
  localparam logic [OVHD_W-1:0]  OVHD_RST  = OVHD_W'(24);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TOKEN_RATE   = 2'd0,
    CFG_BUCKET_DEPTH = 2'd1,
    CFG_MIN_CHARGE   = 2'd2,
    CFG_OVERHEAD     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0]  token_rate;
    logic [DEPTH_W-1:0] bucket_depth;
    logic [MINC_W-1:0]  min_charge;
    logic [OVHD_W-1:0]  per_packet_overhead;
  } cfg_t;

  // Word handed from the refill pipeline to the bucket stage.
  typedef struct packed {
    logic [REFILL_W-1:0] refill;
    logic [CHARGE_W-1:0] charge;
  } refill_t;

endpackage

`default_nettype wire

FILE: sv/tbs_cfg.sv
// Configuration register bank of the token bucket shaper.
`default_nettype none

module tbs_cfg
  import tbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.token_rate          <= RATE_RST;
      cfg.bucket_depth        <= DEPTH_RST;
      cfg.min_charge          <= MINC_RST;
      cfg.per_packet_overhead <= OVHD_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TOKEN_RATE:   cfg.token_rate          <= cfg_wdata[RATE_W-1:0];
        CFG_BUCKET_DEPTH: cfg.bucket_depth        <= cfg_wdata[DEPTH_W-1:0];
        CFG_MIN_CHARGE:   cfg.min_charge          <= cfg_wdata[MINC_W-1:0];
        CFG_OVERHEAD:     cfg.per_packet_overhead <= cfg_wdata[OVHD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/tbs_refill.sv
// Input register, elapsed time, refill product and packet charge stages.
`default_nettype none

module tbs_refill
  import tbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [LEN_W-1:0]  packet_length,
  input  wire logic [TIME_W-1:0] now_us,
  output logic                   b_valid,
  output refill_t                b_data,
  input  wire logic              b_ready
);

  logic                a_valid;
  logic [LEN_W-1:0]    a_len;
  logic [TIME_W-1:0]   a_elapsed;
  logic [TIME_W-1:0]   last_time_us;
  logic                a_ready;
  logic                a_adv;
  logic                b_en;
  logic                in_acc;
  logic [RATE_W+TIME_W-1:0] product;
  logic [CHARGE_W-1:0] charge_raw;
  logic [CHARGE_W-1:0] charge_next;

  // a stage may load when empty or when its word moves on
  assign b_en     = !b_valid || b_ready;
  assign a_ready  = !a_valid || b_en;
  assign a_adv    = a_valid && b_en;
  assign in_ready = a_ready;
  assign in_acc   = in_valid && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      last_time_us <= '0;
    end else begin
      if (in_acc) begin
        a_valid      <= 1'b1;
        last_time_us <= now_us;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  // elapsed wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_len     <= packet_length;
      a_elapsed <= now_us - last_time_us;
    end
  end

  assign product    = RATE_W'(cfg.token_rate) * (RATE_W+TIME_W)'(a_elapsed);
  assign charge_raw = CHARGE_W'(a_len) + CHARGE_W'(cfg.per_packet_overhead);
  assign charge_next = (charge_raw < CHARGE_W'(cfg.min_charge)) ?
                       CHARGE_W'(cfg.min_charge) : charge_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_data.refill <= product[RATE_W+TIME_W-1:TOKEN_SHIFT];
      b_data.charge <= charge_next;
    end
  end

  // a stalled word keeps its elapsed time
  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_en |=> a_valid && $stable(a_elapsed) && $stable(a_len))
    else $error("stage A word lost while stalled");

  // a stalled refill word stays put until the bucket takes it
  b_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_ready |=> b_valid && $stable(b_data))
    else $error("refill word lost while stalled");

  // the last time always follows the last accepted word
  last_track: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> last_time_us == $past(now_us))
    else $error("last time not updated on accept");

endmodule

`default_nettype wire

FILE: sv/tbs_bucket.sv
// Token count update, admission decision and result register.
`default_nettype none

module tbs_bucket
  import tbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                b_valid,
  input  wire refill_t             b_data,
  output logic                     b_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     admitted,
  output logic [CHARGE_W-1:0]      charged_bytes
);

  localparam int SUM_W = REFILL_W + 1;

  logic [TOKEN_W-1:0] token_count;
  logic [TOKEN_W-1:0] token_count_next;
  logic [SUM_W-1:0]   sum;
  logic [TOKEN_W-1:0] cap;
  logic [TOKEN_W-1:0] clamped;
  logic               admit;
  logic               load;

  assign b_ready = !out_valid || out_ready;
  assign load    = b_valid && b_ready;

  assign sum     = SUM_W'(token_count) + SUM_W'(b_data.refill);
  assign cap     = {cfg.bucket_depth, {TOKEN_SHIFT{1'b0}}};
  assign clamped = (sum > SUM_W'(cap)) ? cap : sum[TOKEN_W-1:0];
  assign admit   = b_data.charge <= CHARGE_W'(clamped[TOKEN_W-1:TOKEN_SHIFT]);

  // charge fits 16 bits whenever admitted
  assign token_count_next = admit ?
    clamped - {b_data.charge[TOKEN_W-TOKEN_SHIFT-1:0], {TOKEN_SHIFT{1'b0}}} : clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load) begin
        token_count <= token_count_next;
      end
      if (b_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      admitted      <= admit;
      charged_bytes <= b_data.charge;
    end
  end

  bucket_cap: assert property (@(posedge clk) disable iff (rst)
    load |=> token_count <= $past(cap))
    else $error("token count above bucket depth after update");

  reject_keeps: assert property (@(posedge clk) disable iff (rst)
    load && !admit |=> token_count == $past(clamped) && !admitted)
    else $error("rejected word changed the token count");

  admit_drops: assert property (@(posedge clk) disable iff (rst)
    load && admit |=> token_count < $past(clamped) || $past(b_data.charge) == '0)
    else $error("admitted word did not deduct tokens");

endmodule

`default_nettype wire

FILE: sv/token_bucket_shaper.sv
// Token bucket shaper top level: config bank, refill pipeline, bucket stage.
// An accepted input word passes the stage A register, then the refill register, and its
// result word lands in the output register, from where it can leave. Each of the three
// registers moves on as soon as the one after it is empty or being emptied.
// Throughput: one word per cycle while m_tready is high; the token count update is a single
// add, clamp, compare and subtract in the bucket stage, refill product computed one stage ahead.
// Reset (synchronous, rst high): token count and last time cleared, pipeline emptied,
// registers back to rate 64000, depth 1500, minimum charge 256, overhead 24.
`default_nettype none

module token_bucket_shaper
  import tbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [47:0]           s_tdata,  // [15:0] packet_length, [47:16] now_us
  // decision stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [23:0]                m_tdata   // [0] admitted, [17:1] charged_bytes, rest 0
);

  cfg_t                cfg;
  logic                b_valid;
  logic                b_ready;
  refill_t             b_data;
  logic                admitted;
  logic [CHARGE_W-1:0] charged_bytes;

  // register bank; the user must write it only while the shaper is idle, the bank does not enforce it
  tbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // capture the request, form elapsed time, then refill product and charge
  tbs_refill u_refill (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .packet_length (s_tdata[LEN_W-1:0]),
    .now_us        (s_tdata[LEN_W+TIME_W-1:LEN_W]),
    .b_valid       (b_valid),
    .b_data        (b_data),
    .b_ready       (b_ready)
  );

  // refill and clamp the bucket, decide, deduct, hold the result word
  tbs_bucket u_bucket (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .b_valid       (b_valid),
    .b_data        (b_data),
    .b_ready       (b_ready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .admitted      (admitted),
    .charged_bytes (charged_bytes)
  );

  // pack the result word, pad to whole bytes
  assign m_tdata = {6'b0, charged_bytes, admitted};

endmodule

`default_nettype wire

FILE: bench/tb_token_bucket_shaper.sv
// Self-checking testbench for token_bucket_shaper: directed and random stimulus with a built-in predictor.

module tb_token_bucket_shaper;
  import tbs_pkg::*;

  localparam int ITEMS_PER_PHASE = 140;
  localparam int PHASES          = 10;
  localparam int DRAIN_CYCLES    = 6;   // extra wait after the last expected decision has arrived

  // One expected decision word, split into its fields.
  typedef struct packed {
    logic                admitted;
    logic [CHARGE_W-1:0] charged_bytes;
  } decision_t;

  // Track the bucket and registers, predict each decision, and compare in order.
  class decision_board;
    bit [RATE_W-1:0]  rate;
    bit [DEPTH_W-1:0] depth;
    bit [MINC_W-1:0]  min_chg;
    bit [OVHD_W-1:0]  ovhd;
    bit [TOKEN_W-1:0] tokens;
    bit [TIME_W-1:0]  last_us;
    decision_t        pending[$];
    int unsigned      requests, checked, admits, refusals, errors;

    function new();
      rate    = RATE_RST;
      depth   = DEPTH_RST;
      min_chg = MINC_RST;
      ovhd    = OVHD_RST;
      tokens  = '0;
      last_us = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TOKEN_RATE:   rate    = val[RATE_W-1:0];
        CFG_BUCKET_DEPTH: depth   = val[DEPTH_W-1:0];
        CFG_MIN_CHARGE:   min_chg = val[MINC_W-1:0];
        CFG_OVERHEAD:     ovhd    = val[OVHD_W-1:0];
        default: ;
      endcase
    endfunction

    // Refill, clamp, charge and admit for one accepted request.
    function void note_request(logic [LEN_W-1:0] len, logic [TIME_W-1:0] now);
      bit [TIME_W-1:0]   elapsed;
      bit [63:0]         refill, cap, level;
      bit [CHARGE_W-1:0] charge;
      decision_t         d;
      elapsed = now - last_us;
      refill  = (64'(elapsed) * 64'(rate)) >> TOKEN_SHIFT;
      cap     = 64'(depth) << TOKEN_SHIFT;
      level   = 64'(tokens) + refill;
      if (level > cap)
        level = cap;
      tokens  = level[TOKEN_W-1:0];
      last_us = now;
      charge  = CHARGE_W'(len) + CHARGE_W'(ovhd);
      if (charge < CHARGE_W'(min_chg))
        charge = CHARGE_W'(min_chg);
      d.admitted      = (TOKEN_W'(charge) <= (tokens >> TOKEN_SHIFT));
      d.charged_bytes = charge;
      if (d.admitted) begin
        tokens = tokens - (TOKEN_W'(charge) << TOKEN_SHIFT);
        admits++;
      end else begin
        refusals++;
      end
      requests++;
      pending.push_back(d);
    endfunction

    function void check_decision(logic [23:0] word);
      decision_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: decision word %h arrived with nothing expected", $time, word);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (word[0] !== want.admitted) begin
        errors++;
        $display("%0t: admitted expected %0b actual %0b", $time, want.admitted, word[0]);
      end
      if (word[17:1] !== want.charged_bytes) begin
        errors++;
        $display("%0t: charged_bytes expected %0d actual %0d",
                 $time, want.charged_bytes, word[17:1]);
      end
      if (word[23:18] !== 6'd0) begin
        errors++;
        $display("%0t: pad bits expected 0 actual %b", $time, word[23:18]);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata   = '0;  // [15:0] packet_length, [47:16] now_us
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [23:0]           m_tdata;         // [0] admitted, [17:1] charged_bytes, rest 0

  decision_board   board;
  bit              tx_calm, rx_calm;      // no idling on that side while set
  logic [TIME_W-1:0] clock_us;            // timestamp of the last word sent

  token_bucket_shaper dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold one register write for a cycle, then drop the write enable before the next.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request word after a random gap and hold it until taken.
  task automatic send_request(logic [LEN_W-1:0] len, logic [TIME_W-1:0] now);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, len};
    do @(posedge clk); while (!s_tready);
    board.note_request(len, now);
    clock_us = now;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly forward steps of a few ms, some bursts, some jumps and some backward stamps.
  function automatic logic [TIME_W-1:0] next_stamp(logic [TIME_W-1:0] t);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      return t + $urandom_range(0, 4000);
    else if (pick < 85) return t + $urandom_range(0, 50);
    else if (pick < 95) return $urandom;
    else                return t - $urandom_range(1, 100);
  endfunction

  function automatic logic [LEN_W-1:0] next_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75)      return LEN_W'($urandom_range(0, 1600));
    else if (pick < 85) return LEN_W'($urandom);
    else if (pick < 90) return '0;
    else if (pick < 95) return '1;
    else                return LEN_W'($urandom_range(0, 255));
  endfunction

  // Register settings per phase; phase 0 runs on the reset values.
  task automatic apply_phase(int p);
    case (p)
      1: begin
        write_reg(CFG_TOKEN_RATE,   30'd1 << TOKEN_SHIFT);
        write_reg(CFG_BUCKET_DEPTH, 30'd2000);
        write_reg(CFG_MIN_CHARGE,   30'd64);
        write_reg(CFG_OVERHEAD,     30'd20);
      end
      2: begin
        // no refill at all: drain what is left, then refuse
        write_reg(CFG_TOKEN_RATE,   30'd0);
        write_reg(CFG_MIN_CHARGE,   30'd256);
        write_reg(CFG_OVERHEAD,     30'd24);
      end
      3: begin
        write_reg(CFG_TOKEN_RATE,   30'd1000000000);
        write_reg(CFG_BUCKET_DEPTH, 30'd32768);
        write_reg(CFG_MIN_CHARGE,   30'd0);
        write_reg(CFG_OVERHEAD,     30'd0);
      end
      4: begin
        // drop depth under a full bucket so the next refill clamps down
        write_reg(CFG_BUCKET_DEPTH, 30'd0);
      end
      5: begin
        write_reg(CFG_TOKEN_RATE,   30'h3FFF_FFFF);
        write_reg(CFG_BUCKET_DEPTH, 30'h0000_FFFF);
        write_reg(CFG_MIN_CHARGE,   30'h0000_FFFF);
        write_reg(CFG_OVERHEAD,     30'h0000_00FF);
      end
      6: begin
        // full-width garbage: upper bits must be masked off
        write_reg(CFG_TOKEN_RATE,   CFG_DATA_W'($urandom));
        write_reg(CFG_BUCKET_DEPTH, CFG_DATA_W'($urandom));
        write_reg(CFG_MIN_CHARGE,   CFG_DATA_W'($urandom));
        write_reg(CFG_OVERHEAD,     CFG_DATA_W'($urandom));
      end
      7: begin
        write_reg(CFG_TOKEN_RATE,   30'd20000);
        write_reg(CFG_BUCKET_DEPTH, 30'd1000);
        write_reg(CFG_MIN_CHARGE,   30'd300);
        write_reg(CFG_OVERHEAD,     30'd40);
      end
      8: begin
        write_reg(CFG_TOKEN_RATE,   CFG_DATA_W'($urandom_range(0, 2000000)));
        write_reg(CFG_BUCKET_DEPTH, CFG_DATA_W'($urandom_range(0, 32768)));
        write_reg(CFG_MIN_CHARGE,   CFG_DATA_W'($urandom_range(0, 2000)));
        write_reg(CFG_OVERHEAD,     CFG_DATA_W'($urandom_range(0, 255)));
      end
      9: begin
        write_reg(CFG_TOKEN_RATE,   30'(RATE_RST));
        write_reg(CFG_BUCKET_DEPTH, 30'(DEPTH_RST));
        write_reg(CFG_MIN_CHARGE,   30'(MINC_RST));
        write_reg(CFG_OVERHEAD,     30'(OVHD_RST));
      end
      default: ;
    endcase
  endtask

  // Directed requests on the reset settings: field extremes, time wrap, backward time,
  // charge exactly at and just under the minimum, alternating bit patterns.
  logic [LEN_W-1:0]  dir_len[14] = '{16'd0, 16'd100, 16'hFFFF, 16'd0, 16'd1476, 16'd232,
                                     16'd231, 16'hAAAA, 16'h5555, 16'd0, 16'd300,
                                     16'd1476, 16'd1, 16'hFFFF};
  logic [TIME_W-1:0] dir_now[14] = '{32'd0, 32'd5000, 32'd5001, 32'hFFFF_FFFF, 32'd0,
                                     32'd1, 32'd2, 32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_0000, 32'h5555_0000, 32'h5555_6000,
                                     32'h5556_0000, 32'hFFFF_FFFF};

  // Receiver: stall at random before each word, then take it and check it.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_decision(m_tdata);
    end
  end

  // Sender and phase sequencing.
  initial begin
    board    = new();
    clock_us = '0;
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 14; i++)
      send_request(dir_len[i], dir_now[i]);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        s_tvalid <= 1'b0;
        wait_drained();
        apply_phase(p);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // redraw the idling pattern every few dozen words
        if (n % 32 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        send_request(next_length(), next_stamp(clock_us));
      end
    end
    s_tvalid <= 1'b0;
    rx_calm = 1'b0;
    wait_drained();

    if (board.pending.size() != 0) begin
      board.errors++;
      $display("%0t: %0d decisions never arrived", $time, board.pending.size());
    end
    $display("run covered %0d requests over %0d register settings", board.requests, PHASES);
    $display("decisions checked %0d: %0d admitted, %0d refused",
             board.checked, board.admits, board.refusals);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("timeout waiting on the shaper");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
sv/tbs_pkg.sv
sv/tbs_cfg.sv
sv/tbs_refill.sv
sv/tbs_bucket.sv
sv/token_bucket_shaper.sv
bench/tb_token_bucket_shaper.sv
